### rtl/core/isq_pkg.sv
// shared types and constants for the indexed sequence store
`default_nettype none

package isq_pkg;

   localparam int CMD_W   = 2;
   localparam int POS_W   = 5;
   localparam int VAL_W   = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   localparam logic [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_DELETE = 2'd2
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADIDX = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic              insert_en;
      logic              delete_en;
      logic [POS_W-1:0]  position;
      logic [VAL_W-1:0]  value;
   } cell_op_type;

endpackage

`default_nettype wire

### rtl/core/isq_if.sv
// request and response channel interfaces
`default_nettype none

interface isq_req_if;
   logic                               valid;
   logic                               ready;
   logic [isq_pkg::CMD_W-1:0]          command;
   logic [isq_pkg::POS_W-1:0]          position;
   logic signed [isq_pkg::VAL_W-1:0]   item_value;

   modport source (output valid, command, position, item_value, input ready);
   modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface isq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [isq_pkg::VAL_W-1:0]   read_value;
   logic [isq_pkg::STAT_W-1:0]         status;
   logic [isq_pkg::COUNT_W-1:0]        item_count;

   modport source (output valid, read_value, status, item_count, input ready);
   modport sink   (input valid, read_value, status, item_count, output ready);
endinterface

`default_nettype wire

### rtl/core/isq_cell.sv
// one storage cell of the sequence chain
`default_nettype none

module isq_cell #(
   parameter int INDEX = 0
) (
   input  wire                          clock,
   input  wire isq_pkg::cell_op_type    op,
   input  wire [isq_pkg::VAL_W-1:0]     left_value,
   input  wire [isq_pkg::VAL_W-1:0]     right_value,
   output logic [isq_pkg::VAL_W-1:0]    value
);

   logic [isq_pkg::VAL_W-1:0] value_ff;
   logic [isq_pkg::VAL_W-1:0] value_in;
   int                        pos_int;

   always_comb begin
      pos_int  = int'(op.position);
      value_in = value_ff;
      if (op.insert_en) begin
         if (INDEX == pos_int) begin
            value_in = op.value;
         end else if (INDEX > pos_int) begin
            value_in = left_value;
         end
      end else if (op.delete_en) begin
         if (INDEX >= pos_int) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

### rtl/core/indexed_sequence_store.sv
// top level of the indexed sequence store
// Holds an ordered list of up to CAPACITY signed 32-bit values in a row of
// cells. Each request on req_chan carries a command (insert, read, delete),
// a position and a value; each yields one response on rsp_chan with the
// read value, a status and the new entry count.
// Insert at a position shifts every cell behind it one place toward the end
// in the same cycle; delete shifts them one place toward the front. A read
// selects the addressed cell; only the first 32 cells are reachable, as the
// position is 5 bits wide.
// The response is registered and is valid the cycle after the request is taken.
// One request per cycle while responses are drained, as every cell shifts at once.
// The response sits in an output register; a new request is taken whenever
// that register is empty or being drained, so a stalled receiver holds
// req_chan.ready low until it takes the waiting response.
// Reset clears the entry count and the response valid; cell contents are
// left as they are and are never read before being written.
// On any error the list and count are unchanged and the read value is the
// most negative integer.
`default_nettype none

module indexed_sequence_store #(
   parameter int CAPACITY = 16
) (
   input  wire         clock,
   input  wire         reset,
   isq_req_if.sink     req_chan,
   isq_rsp_if.source   rsp_chan
);

   localparam int VAL_W   = isq_pkg::VAL_W;
   localparam int POS_W   = isq_pkg::POS_W;
   localparam int COUNT_W = isq_pkg::COUNT_W;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int READ_N  = (CAPACITY < 32) ? CAPACITY : 32;

   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        rsp_valid_ff;
   logic [VAL_W-1:0]            read_value_ff;
   logic [VAL_W-1:0]            read_value_in;
   isq_pkg::status_type         status_ff;
   isq_pkg::status_type         status_in;
   logic [COUNT_W-1:0]          item_count_ff;

   logic                        accept;
   logic                        ins_ok;
   logic                        del_ok;
   logic [CMP_W-1:0]            pos_ext;
   logic [CMP_W-1:0]            cnt_ext;
   logic [VAL_W-1:0]            rd_sel;
   isq_pkg::cell_op_type        op;
   logic [VAL_W-1:0]            cell_value [CAPACITY];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_ext = CMP_W'(req_chan.position);
   assign cnt_ext = CMP_W'(count_ff);

   always_comb begin
      rd_sel = '0;
      for (int k = 0; k < READ_N; k++) begin
         if (POS_W'(k) == req_chan.position) begin
            rd_sel = cell_value[k];
         end
      end
   end

   always_comb begin
      ins_ok        = 1'b0;
      del_ok        = 1'b0;
      status_in     = isq_pkg::ST_BADIDX;
      read_value_in = isq_pkg::MOST_NEG;
      case (req_chan.command)
         isq_pkg::CMD_INSERT: begin
            if (count_ff == CNT_W'(CAPACITY)) begin
               status_in = isq_pkg::ST_FULL;
            end else if (pos_ext <= cnt_ext) begin
               ins_ok        = 1'b1;
               status_in     = isq_pkg::ST_OK;
               read_value_in = '0;
            end
         end
         isq_pkg::CMD_READ: begin
            if (pos_ext < cnt_ext) begin
               status_in     = isq_pkg::ST_OK;
               read_value_in = rd_sel;
            end
         end
         isq_pkg::CMD_DELETE: begin
            if (count_ff == '0) begin
               status_in = isq_pkg::ST_EMPTY;
            end else if (pos_ext < cnt_ext) begin
               del_ok        = 1'b1;
               status_in     = isq_pkg::ST_OK;
               read_value_in = '0;
            end
         end
         default: begin
            status_in = isq_pkg::ST_BADIDX;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept && ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (accept && del_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign op.insert_en = accept && ins_ok;
   assign op.delete_en = accept && del_ok;
   assign op.position  = req_chan.position;
   assign op.value     = req_chan.item_value;

   // cell chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VAL_W-1:0] left_v;
      logic [VAL_W-1:0] right_v;
      if (g == 0) begin : g_first
         assign left_v = req_chan.item_value;
      end else begin : g_mid_l
         assign left_v = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_v = cell_value[g];
      end else begin : g_mid_r
         assign right_v = cell_value[g+1];
      end
      isq_cell #(
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .op          (op),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_value[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value_in;
         status_ff     <= status_in;
         item_count_ff <= COUNT_W'(CMP_W'(count_in));
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = read_value_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.item_count = item_count_ff;

   // count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // an accepted request always yields a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("response missing after request");

   // errors leave the count unchanged
   a_err_no_change: assert property (@(posedge clock) disable iff (reset)
      accept && (status_in != isq_pkg::ST_OK) |=> count_ff == $past(count_ff))
      else $error("count changed on error");

   // a good insert grows the count by one
   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      accept && ins_ok |=> count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow count");

endmodule

`default_nettype wire
